// ===== src/tlc_pkg.sv =====
package tlc_pkg;

   // result operation codes
   typedef enum logic [1:0] {
      OP_PUT_CHAR   = 2'd0,
      OP_PUT_DOUBLE = 2'd1,
      OP_FILL       = 2'd2,
      OP_LINE_END   = 2'd3
   } op_type;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_VIEW_WIDTH = 2'd0,
      CSR_HSKIP      = 2'd1,
      CSR_TAB_WIDTH  = 2'd2,
      CSR_ENCODING   = 2'd3
   } csr_index_type;

   // encoding modes (any other code behaves as plain ascii)
   localparam logic [1:0] ENC_SJIS = 2'd1;
   localparam logic [1:0] ENC_EUC  = 2'd2;

   // special bytes and lead byte ranges
   localparam logic [7:0] BYTE_NUL      = 8'h00;
   localparam logic [7:0] BYTE_TAB      = 8'h09;
   localparam logic [7:0] BYTE_NEWLINE  = 8'h0a;
   localparam logic [7:0] BYTE_SPACE    = 8'h20;
   localparam logic [7:0] SJIS_LO1      = 8'h81;
   localparam logic [7:0] SJIS_HI1      = 8'h9f;
   localparam logic [7:0] SJIS_LO2      = 8'he0;
   localparam logic [7:0] SJIS_HI2      = 8'hfc;
   localparam logic [7:0] EUC_LO        = 8'ha1;
   localparam logic [7:0] EUC_HI        = 8'hfe;

   // limits
   localparam logic [6:0]  MIN_VIEW_WIDTH = 7'd20;
   localparam logic [8:0]  MAX_TAB_WIDTH  = 9'd256;
   localparam logic [12:0] COLUMN_LIMIT   = 13'd4095;

   // reset values of the configuration registers
   localparam logic [6:0]  RST_VIEW_WIDTH = 7'd30;
   localparam logic [11:0] RST_HSKIP      = 12'd0;
   localparam logic [8:0]  RST_TAB_WIDTH  = 9'd4;
   localparam logic [1:0]  RST_ENCODING   = 2'd0;

   // line state carried from one transaction to the next
   typedef struct packed {
      logic signed [12:0] cursor;
      logic [7:0]         phase;
      logic               pending;
      logic [7:0]         lead;
   } line_state_type;

   // result of one transaction
   typedef struct packed {
      logic       emit;
      op_type     op;
      logic [6:0] column;
      logic [6:0] count;
      logic [7:0] first_byte;
      logic [7:0] second_byte;
   } result_type;

endpackage

// ===== src/tlc_phase_norm.sv =====
module tlc_phase_norm (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [7:0] phase_value,
   input  logic [8:0] divisor,
   output logic       busy,
   output logic       done,
   output logic [7:0] result
);

   logic [7:0]  rem_ff, rem_in;
   logic [15:0] ds_ff;
   logic [2:0]  cnt_ff;
   logic        busy_ff;
   logic        ge;

   // one restoring step: subtract the shifted divisor when it fits
   always_comb begin
      ge     = {8'd0, rem_ff} >= ds_ff;
      rem_in = ge ? (rem_ff - ds_ff[7:0]) : rem_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 3'd0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= 3'd7;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 3'd1;
         if (cnt_ff == 3'd0) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // remainder and divisor datapath
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= phase_value;
         ds_ff  <= {divisor, 7'd0};
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         ds_ff  <= ds_ff >> 1;
      end
   end

   assign busy   = busy_ff;
   assign done   = busy_ff && (cnt_ff == 3'd0);
   assign result = rem_in;

endmodule

// ===== src/tlc_step.sv =====
module tlc_step (
   input  logic                   [7:0] text_byte,
   input  tlc_pkg::line_state_type      state,
   input  logic                   [6:0] eff_width,
   input  logic                   [8:0] eff_tab,
   input  logic                   [1:0] encoding,
   input  logic                  [11:0] horizontal_skip,
   output tlc_pkg::result_type          result,
   output tlc_pkg::line_state_type      next_state
);

   logic signed [14:0] x;
   logic signed [14:0] w;
   logic signed [14:0] lo;
   logic signed [14:0] hi;
   logic signed [14:0] adv_sum;
   logic signed [14:0] len;
   logic [8:0]         tab_n;
   logic [8:0]         adv_n;
   logic               do_adv;
   logic               is_lead;
   logic [9:0]         phase_sum;
   logic [7:0]         phase_adv;
   logic [12:0]        cursor_adv;

   always_comb begin
      x     = {{2{state.cursor[12]}}, state.cursor};
      w     = {8'd0, eff_width};
      tab_n = eff_tab - {1'b0, state.phase};
      lo    = (x < 15'sd0) ? 15'sd0 : x;
      hi    = x + {6'd0, tab_n};
      if (hi > w) begin
         hi = w;
      end
      len = (x > w) ? w : x;
      if (len < 15'sd0) begin
         len = 15'sd0;
      end
   end

   // lead byte detection
   always_comb begin
      if (encoding == tlc_pkg::ENC_SJIS) begin
         is_lead = (text_byte >= tlc_pkg::SJIS_LO1 && text_byte <= tlc_pkg::SJIS_HI1) ||
                   (text_byte >= tlc_pkg::SJIS_LO2 && text_byte <= tlc_pkg::SJIS_HI2);
      end else if (encoding == tlc_pkg::ENC_EUC) begin
         is_lead = text_byte >= tlc_pkg::EUC_LO && text_byte <= tlc_pkg::EUC_HI;
      end else begin
         is_lead = 1'b0;
      end
   end

   // byte classification and result selection
   always_comb begin
      result      = '0;
      result.op   = tlc_pkg::OP_PUT_CHAR;
      next_state  = state;
      do_adv      = 1'b0;
      adv_n       = 9'd1;
      if (state.pending) begin
         next_state.pending = 1'b0;
         do_adv = 1'b1;
         adv_n  = 9'd2;
         if (x == -15'sd1) begin
            result.emit       = 1'b1;
            result.first_byte = tlc_pkg::BYTE_SPACE;
         end else if (x >= 15'sd0 && x < w - 15'sd1) begin
            result.emit        = 1'b1;
            result.op          = tlc_pkg::OP_PUT_DOUBLE;
            result.column      = x[6:0];
            result.first_byte  = state.lead;
            result.second_byte = text_byte;
         end else if (x == w - 15'sd1) begin
            result.emit       = 1'b1;
            result.column     = x[6:0];
            result.first_byte = tlc_pkg::BYTE_SPACE;
         end
      end else if (text_byte == tlc_pkg::BYTE_NUL || text_byte == tlc_pkg::BYTE_NEWLINE) begin
         result.emit        = 1'b1;
         result.op          = tlc_pkg::OP_LINE_END;
         result.count       = len[6:0];
         next_state.cursor  = -$signed({1'b0, horizontal_skip});
         next_state.phase   = 8'd0;
         next_state.pending = 1'b0;
         next_state.lead    = 8'd0;
      end else if (text_byte == tlc_pkg::BYTE_TAB) begin
         do_adv = 1'b1;
         adv_n  = tab_n;
         if (hi > lo) begin
            result.emit   = 1'b1;
            result.op     = tlc_pkg::OP_FILL;
            result.column = lo[6:0];
            result.count  = 7'(hi - lo);
         end
      end else if (is_lead) begin
         next_state.pending = 1'b1;
         next_state.lead    = text_byte;
      end else begin
         do_adv = 1'b1;
         if (x >= 15'sd0 && x < w) begin
            result.emit       = 1'b1;
            result.column     = x[6:0];
            result.first_byte = text_byte;
         end
      end
      if (do_adv) begin
         next_state.cursor = cursor_adv;
         next_state.phase  = phase_adv;
      end
   end

   // cursor advance with saturation and tab phase wrap
   always_comb begin
      adv_sum = x + {6'd0, adv_n};
      if (adv_sum > $signed({2'd0, tlc_pkg::COLUMN_LIMIT})) begin
         cursor_adv = tlc_pkg::COLUMN_LIMIT;
      end else begin
         cursor_adv = adv_sum[12:0];
      end
      phase_sum = {2'd0, state.phase} + {1'b0, adv_n};
      if (eff_tab == 9'd1) begin
         phase_adv = 8'd0;
      end else if (phase_sum >= {1'b0, eff_tab}) begin
         phase_adv = 8'(phase_sum - {1'b0, eff_tab});
      end else begin
         phase_adv = phase_sum[7:0];
      end
   end

endmodule

// ===== src/text_line_composer.sv =====
// text line composer: one text byte per transaction in, at most one write command out
// path: a byte is held in the input register, and its result is presented from the result register
// throughput: one byte per cycle unless the output stalls; a tab_width write stalls input while
//   the stored tab phase is reduced modulo the new width by an 8-step divider
// reset: synchronous; registers take their reset values and the line starts at column 0
module text_line_composer #(
   parameter int MAX_WIDTH = 126
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_text_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_op,
   output logic [6:0]  rsp_column,
   output logic [6:0]  rsp_count,
   output logic [7:0]  rsp_first_byte,
   output logic [7:0]  rsp_second_byte,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_write_data
);

   localparam logic [6:0] MaxWidth = 7'(MAX_WIDTH);

   logic [6:0]  view_width_ff;
   logic [11:0] hskip_ff;
   logic [8:0]  tab_width_ff;
   logic [1:0]  encoding_ff;

   logic [6:0] eff_width;
   logic [8:0] eff_tab;

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;

   tlc_pkg::line_state_type state_ff, state_in;
   tlc_pkg::result_type     step_result;
   tlc_pkg::result_type     rsp_ff;
   logic                    rsp_valid_ff;
   logic [7:0]              phase_raw_ff;

   logic       norm_start_ff;
   logic       norm_busy;
   logic       norm_done;
   logic [7:0] norm_result;

   logic out_ready;
   logic go;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         view_width_ff <= tlc_pkg::RST_VIEW_WIDTH;
         hskip_ff      <= tlc_pkg::RST_HSKIP;
         tab_width_ff  <= tlc_pkg::RST_TAB_WIDTH;
         encoding_ff   <= tlc_pkg::RST_ENCODING;
      end else if (csr_write_enable) begin
         unique case (tlc_pkg::csr_index_type'(csr_index))
            tlc_pkg::CSR_VIEW_WIDTH: view_width_ff <= csr_write_data[6:0];
            tlc_pkg::CSR_HSKIP:      hskip_ff      <= csr_write_data;
            tlc_pkg::CSR_TAB_WIDTH:  tab_width_ff  <= csr_write_data[8:0];
            tlc_pkg::CSR_ENCODING:   encoding_ff   <= csr_write_data[1:0];
            default:                 hskip_ff      <= hskip_ff;
         endcase
      end
   end

   // saturated register values
   always_comb begin
      eff_width = view_width_ff;
      if (eff_width < tlc_pkg::MIN_VIEW_WIDTH) begin
         eff_width = tlc_pkg::MIN_VIEW_WIDTH;
      end
      if (eff_width > MaxWidth) begin
         eff_width = MaxWidth;
      end
      eff_tab = tab_width_ff;
      if (eff_tab == 9'd0) begin
         eff_tab = 9'd1;
      end
      if (eff_tab > tlc_pkg::MAX_TAB_WIDTH) begin
         eff_tab = tlc_pkg::MAX_TAB_WIDTH;
      end
   end

   // phase reduction starts the cycle after a tab width write
   always_ff @(posedge clock) begin
      if (reset) begin
         norm_start_ff <= 1'b0;
      end else begin
         norm_start_ff <= csr_write_enable &&
                          (tlc_pkg::csr_index_type'(csr_index) == tlc_pkg::CSR_TAB_WIDTH);
      end
   end

   // tab phase as last advanced, kept unreduced so each new tab width starts from it
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_raw_ff <= 8'd0;
      end else if (go && !state_in.pending) begin
         phase_raw_ff <= state_in.phase;
      end
   end

   tlc_phase_norm u_phase_norm (
      .clock       (clock),
      .reset       (reset),
      .start       (norm_start_ff),
      .phase_value (phase_raw_ff),
      .divisor     (eff_tab),
      .busy        (norm_busy),
      .done        (norm_done),
      .result      (norm_result)
   );

   // handshake control
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign go        = in_valid_ff && out_ready && !norm_busy && !norm_start_ff;
   assign req_stall = norm_busy || norm_start_ff || (in_valid_ff && !go);

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_valid_ff <= 1'b1;
      end else if (go) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_text_byte;
      end
   end

   tlc_step u_step (
      .text_byte       (in_byte_ff),
      .state           (state_ff),
      .eff_width       (eff_width),
      .eff_tab         (eff_tab),
      .encoding        (encoding_ff),
      .horizontal_skip (hskip_ff),
      .result          (step_result),
      .next_state      (state_in)
   );

   // line state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.cursor  <= -$signed({1'b0, tlc_pkg::RST_HSKIP});
         state_ff.phase   <= 8'd0;
         state_ff.pending <= 1'b0;
         state_ff.lead    <= 8'd0;
      end else if (norm_done) begin
         state_ff.phase <= norm_result;
      end else if (go) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (go && step_result.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (go && step_result.emit) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_op          = rsp_ff.op;
   assign rsp_column      = rsp_ff.column;
   assign rsp_count       = rsp_ff.count;
   assign rsp_first_byte  = rsp_ff.first_byte;
   assign rsp_second_byte = rsp_ff.second_byte;

endmodule
